[rtl/ncdf_pkg.sv]
`timescale 1ns / 1ps

package ncdf_pkg;

  // Default formats
  localparam int IN_FRAC_BITS_DEF = 12;
  localparam int OUT_BITS_DEF     = 16;

  // Internal fixed point: Q24
  localparam int FB = 24;
  localparam logic [24:0] ONE = 25'h100_0000;

  // Signed width of the polynomial accumulator
  localparam int PW = 28;

  localparam logic [23:0] INV_SQRT2 = 24'd11863283;
  localparam logic [22:0] COEF_P    = 23'd5496067;
  localparam logic [23:0] LN2       = 24'd11629080;
  // floor(2^40 / LN2), for k = w / LN2 by reciprocal
  localparam logic [16:0] INV_LN2   = 17'd94548;
  // Beyond 40 * LN2 the exponential has underflowed to zero
  localparam logic [28:0] W_LIM     = 29'd465163200;

  localparam int EXP_TERMS = 12;

  // floor(2^32 / n), but 2^32 - 1 for n = 1, for the series' truncating divisions
  localparam logic [31:0] EXP_RECIP [1:12] = '{
    32'd4294967295, 32'd2147483648, 32'd1431655765, 32'd1073741824,
    32'd858993459,  32'd715827882,  32'd613566756,  32'd536870912,
    32'd477218588,  32'd429496729,  32'd390451572,  32'd357913941
  };

  // Leading coefficient a5, then the addends of each Horner step (a4 .. a1, none)
  localparam logic signed [PW-1:0] COEF_A5 = 28'sd17807428;
  localparam logic signed [PW-1:0] HORNER_ADD [0:4] = '{
    -28'sd24379845, 28'sd23847365, -28'sd4773063, 28'sd4275331, 28'sd0
  };

endpackage

[rtl/normal_cdf_approximation_top.sv]
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit up)              Meaning
// in_      in   [15:0] sample_value, signed     x, Q4.12 by default
// out_     out  [OUT_BITS-1:0] probability      Phi(x), Q0.OUT_BITS, saturated
//
// One item per clock while the skid register is empty; a full skid register holds in_tready low.
// The pipeline depth is set by the twelve-term exponential series, three stages per term
// (multiply, reciprocal multiply, correct), which runs beside the bit-per-stage divider.
// rst_n is synchronous, active low, and clears the valid bits and the skid flag.
// A stall on out_ first parks the finished result in a one-entry skid register while
// the pipeline advances once more; only then is the whole pipeline held in place.

module normal_cdf_approximation_top
  import ncdf_pkg::*;
#(
  parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF,
  parameter int OUT_BITS     = OUT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [15:0] sample_value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [((OUT_BITS+7)/8)*8-1:0]   out_tdata   // [OUT_BITS-1:0] probability
);

  localparam int A_W    = 16 + FB - IN_FRAC_BITS;       // |x| in Q24
  localparam int AZ_W   = A_W + 24;                     // a * INV_SQRT2
  localparam int AA_W   = 2 * A_W;                      // a * a
  localparam int W_W    = AA_W - 25;                    // x*x/2 in Q24
  localparam int WX_W   = (W_W > 29) ? W_W : 29;
  localparam int PZ_W   = A_W + 23;                     // P * z
  localparam int DEN_W  = ((A_W > 25) ? A_W : 25) + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int OD_W   = ((OUT_BITS + 7) / 8) * 8;
  localparam int CO_W   = 25 + OUT_BITS + 1;
  localparam int LAST   = 45;

  localparam logic [OUT_BITS:0] MAX_O = {1'b0, {OUT_BITS{1'b1}}};

  logic            pipe_en;
  logic [LAST:0]   vld_r;
  logic            skid_v_r;
  logic [OUT_BITS-1:0] skid_r;
  logic [OUT_BITS-1:0] out_r;

  // Handshake: the pipeline moves whenever the skid register is free
  assign pipe_en    = !skid_v_r;
  assign in_tready  = pipe_en;
  assign out_tvalid = skid_v_r | vld_r[LAST];
  assign out_tdata  = OD_W'(skid_v_r ? skid_r : out_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[LAST-1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (vld_r[LAST] && !out_tready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_r <= out_r;
    end
  end

  // ---------------------------------------------------------------- stage 0: magnitude
  logic [15:0]    mag_nxt;
  logic [A_W-1:0] a0_r;
  logic           neg_r [0:43];

  assign mag_nxt = in_tdata[15] ? (16'd0 - in_tdata) : in_tdata;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a0_r     <= A_W'(mag_nxt) << (FB - IN_FRAC_BITS);
      neg_r[0] <= in_tdata[15];
    end
  end

  for (genvar s = 1; s <= 43; s++) begin : g_neg
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: z and w
  logic [AZ_W-1:0] az_nxt;
  logic [AA_W-1:0] aa_nxt;
  logic [A_W-1:0]  z1_r;
  logic [W_W-1:0]  w1_r;

  assign az_nxt = AZ_W'(a0_r) * AZ_W'(INV_SQRT2);
  assign aa_nxt = AA_W'(a0_r) * AA_W'(a0_r);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      z1_r <= az_nxt[AZ_W-1:24];
      w1_r <= aa_nxt[AA_W-1:25];
    end
  end

  // ---------------------------------------------------------------- stage 2: den, k estimate
  logic [PZ_W-1:0]  pz_nxt;
  logic [WX_W-1:0]  wx_nxt;
  logic [DEN_W-1:0] den_r [2:26];
  logic [45:0]      kp2_r;
  logic [28:0]      w2_r;
  logic             big_r [2:41];

  assign pz_nxt = PZ_W'(z1_r) * PZ_W'(COEF_P);
  assign wx_nxt = WX_W'(w1_r);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      den_r[2] <= DEN_W'(ONE) + DEN_W'(pz_nxt >> 24);
      kp2_r    <= 46'(wx_nxt[28:0]) * 46'(INV_LN2);
      w2_r     <= wx_nxt[28:0];
      big_r[2] <= wx_nxt >= WX_W'(W_LIM);
    end
  end

  for (genvar s = 3; s <= 41; s++) begin : g_big
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        big_r[s] <= big_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------- stages 3..5: range reduction
  logic [5:0]  kest3_r;
  logic [28:0] w3_r;
  logic [28:0] rr4_r;
  logic [5:0]  k4_r;
  logic [5:0]  k_r [5:41];
  logic [23:0] r_r [5:38];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      kest3_r <= kp2_r[45:40];
      w3_r    <= w2_r;
      rr4_r   <= w3_r - 29'(30'(kest3_r) * 30'(LN2));
      k4_r    <= kest3_r;
      // estimate is k or k-1: one correction
      if (rr4_r >= 29'(LN2)) begin
        r_r[5] <= 24'(rr4_r - 29'(LN2));
        k_r[5] <= k4_r + 6'd1;
      end else begin
        r_r[5] <= rr4_r[23:0];
        k_r[5] <= k4_r;
      end
    end
  end

  for (genvar s = 6; s <= 41; s++) begin : g_k
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        k_r[s] <= k_r[s-1];
      end
    end
  end

  for (genvar s = 6; s <= 38; s++) begin : g_r
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        r_r[s] <= r_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------- stages 6..41: exp(-r)
  // e = 1 - ((r*e) >> 24) / n for n = 12 down to 1, three stages per term
  logic [47:0] ex_p_r [0:EXP_TERMS-1];
  logic [23:0] ex_v_r [0:EXP_TERMS-1];
  logic [23:0] ex_q_r [0:EXP_TERMS-1];
  logic [24:0] ex_e_r [0:EXP_TERMS-1];

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_exp
    localparam int NT = EXP_TERMS - j;
    logic [24:0] e_in;
    logic [55:0] qe_nxt;
    logic [23:0] rem_nxt;
    logic        fix_nxt;

    if (j == 0) begin : g_first
      assign e_in = ONE;
    end else begin : g_next
      assign e_in = ex_e_r[j-1];
    end

    assign qe_nxt  = 56'(ex_p_r[j][47:24]) * 56'(EXP_RECIP[NT]);
    assign rem_nxt = ex_v_r[j] - 24'(ex_q_r[j] * 24'(NT));
    assign fix_nxt = rem_nxt >= 24'(NT);

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        ex_p_r[j] <= 48'(r_r[5+3*j]) * 48'(e_in);
        ex_v_r[j] <= ex_p_r[j][47:24];
        ex_q_r[j] <= qe_nxt[55:32];
        ex_e_r[j] <= ONE - 25'(ex_q_r[j] + 24'(fix_nxt));
      end
    end
  end

  // ---------------------------------------------------------------- stage 42: scale by 2^-k
  logic [24:0] e42_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      e42_r <= big_r[41] ? 25'd0 : (ex_e_r[EXP_TERMS-1] >> k_r[41]);
    end
  end

  // ---------------------------------------------------------------- stages 3..27: t = 1/den
  // restoring division of 2^48 + den/2, one quotient bit per stage
  logic [REM_W-1:0] rem_r [3:27];
  logic [24:0]      quo_r [3:27];

  for (genvar i = 0; i < 25; i++) begin : g_div
    logic [REM_W-1:0] rin;
    logic [24:0]      qin;
    logic [REM_W-1:0] sh;
    logic             ge;

    if (i == 0) begin : g_first
      assign rin = REM_W'(25'h80_0000) + REM_W'(den_r[2] >> 26);
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[2+i];
      assign qin = quo_r[2+i];
    end

    assign sh = {rin[REM_W-2:0], den_r[2+i][25-i]};
    assign ge = sh >= {1'b0, den_r[2+i]};

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        rem_r[3+i] <= ge ? (sh - {1'b0, den_r[2+i]}) : sh;
        quo_r[3+i] <= {qin[23:0], ge};
      end
    end

    if (i < 24) begin : g_den
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          den_r[3+i] <= den_r[2+i];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stages 28..37: Horner
  logic [24:0]          tl_r [28:35];
  logic [52:0]          hm_r [0:4];
  logic                 hs_r [0:4];
  logic signed [PW-1:0] hp_r [0:4];
  logic signed [PW-1:0] pd_r [38:42];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      tl_r[28] <= quo_r[27];
    end
  end

  for (genvar s = 29; s <= 35; s++) begin : g_t
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        tl_r[s] <= tl_r[s-1];
      end
    end
  end

  for (genvar i = 0; i < 5; i++) begin : g_horner
    logic signed [PW-1:0] pin;
    logic [24:0]          tin;
    logic [PW-1:0]        pmag;
    logic [52:0]          rsum;
    logic signed [PW-1:0] rnd;

    if (i == 0) begin : g_first
      assign pin = COEF_A5;
      assign tin = quo_r[27];
    end else begin : g_next
      assign pin = hp_r[i-1];
      assign tin = tl_r[27+2*i];
    end

    assign pmag = pin[PW-1] ? (PW'(0) - pin) : pin;
    assign rsum = hm_r[i] + 53'h80_0000;
    assign rnd  = PW'(rsum >> 24);

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        hm_r[i] <= 53'(pmag) * 53'(tin);
        hs_r[i] <= pin[PW-1];
        hp_r[i] <= (hs_r[i] ? -rnd : rnd) + HORNER_ADD[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pd_r[38] <= hp_r[4];
    end
  end

  for (genvar s = 39; s <= 42; s++) begin : g_pd
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        pd_r[s] <= pd_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------- stages 43..45: combine
  logic [PW-1:0]      fmag_nxt;
  logic [52:0]        fm_r;
  logic               fs_r;
  logic [28:0]        qr_nxt;
  logic signed [29:0] qs_nxt;
  logic signed [29:0] y_nxt;
  logic [24:0]        yc_nxt;
  logic [25:0]        csum_nxt;
  logic [24:0]        c_r;
  logic [CO_W-1:0]    o_nxt;

  assign fmag_nxt = pd_r[42][PW-1] ? (PW'(0) - pd_r[42]) : pd_r[42];
  assign qr_nxt   = 29'((fm_r + 53'h80_0000) >> 24);
  assign qs_nxt   = fs_r ? -$signed({1'b0, qr_nxt}) : $signed({1'b0, qr_nxt});
  assign y_nxt    = $signed(30'(ONE)) - qs_nxt;

  always_comb begin
    priority if (y_nxt < 0) begin
      yc_nxt = '0;
    end else if (y_nxt > $signed(30'(ONE))) begin
      yc_nxt = ONE;
    end else begin
      yc_nxt = y_nxt[24:0];
    end
  end

  assign csum_nxt = neg_r[43] ? (26'(ONE) - 26'(yc_nxt)) : (26'(ONE) + 26'(yc_nxt));
  assign o_nxt    = ((CO_W'(c_r) << OUT_BITS) + CO_W'(25'h80_0000)) >> 24;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      fm_r  <= 53'(fmag_nxt) * 53'(e42_r);
      fs_r  <= pd_r[42][PW-1];
      c_r   <= csum_nxt[25:1];
      out_r <= (o_nxt > CO_W'(MAX_O)) ? MAX_O[OUT_BITS-1:0] : o_nxt[OUT_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------- checks
  a_skid_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !in_tready)
    else $error("input taken while skid register full");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_tready |=> skid_v_r)
    else $error("skid register dropped a result");

  a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r))
    else $error("valid bits moved during stall");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted transfer not tracked");

  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && big_r[41] |=> e42_r == 25'd0)
    else $error("exponential not flushed to zero");

endmodule
